// ----- hdl/tdf_pkg.sv -----
// tdf_pkg: shared constants of the trial division factorizer
// no dependencies; imported by the top level

package tdf_pkg;

  // default width of the value that is factored
  localparam int VALUE_BITS_DEF = 32;

  // fixed port widths
  localparam int IN_W    = 32;
  localparam int PRIME_W = 32;
  localparam int EXP_W   = 6;

  // results per item are capped at this count
  localparam int MAX_RESULTS = 9;
  localparam int K_W         = $clog2(MAX_RESULTS + 1);

endpackage

// ----- hdl/tdf_div.sv -----
// tdf_div: iterative restoring divider, one quotient bit per cycle
// standalone, no package needed; used by trial_division_factorizer_core

module tdf_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CW'(W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift in next dividend bit, subtract when it fits
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- hdl/trial_division_factorizer_core.sv -----
// trial_division_factorizer_core: top level, sequencer around one shared divider
// depends on tdf_pkg and tdf_div
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------------
//  input   | start, busy, in_value[31:0]             | taken when start && !busy
//  result  | out_valid, out_prime_factor[31:0],      | one-cycle strobe, no stall
//          | out_exponent[5:0], out_last, out_no_factor|
//
// each trial of a divisor is one run of the shared divider
// an item takes one divider run per trial division, up to about 65536 runs
// for a 32-bit prime; 0 and 1 answer next cycle
// reset is synchronous, active low, and returns the sequencer to idle
// results leave as single-cycle strobes; the receiver has no way to hold them

module trial_division_factorizer_core
  import tdf_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [IN_W-1:0]    in_value,
  output logic               out_valid,
  output logic [PRIME_W-1:0] out_prime_factor,
  output logic [EXP_W-1:0]   out_exponent,
  output logic               out_last,
  output logic               out_no_factor
);

  localparam int VB = VALUE_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,   // waiting for an item
    S_WAIT = 3'b010,   // divider running on rest / d
    S_TAIL = 3'b100    // leftover cofactor goes out as final result
  } state_t;

  state_t state_r, state_nxt;

  logic [VB-1:0]    rest_r, rest_nxt;     // remaining cofactor
  logic [VB-1:0]    d_r, d_nxt;           // current trial divisor
  logic [EXP_W-1:0] cnt_r, cnt_nxt;       // multiplicity of d so far
  logic [K_W-1:0]   k_r, k_nxt;           // results taken so far, incl. pending
  logic             pend_v_r, pend_v_nxt; // one result held back for the last flag
  logic [VB-1:0]    pend_p_r, pend_p_nxt;
  logic [EXP_W-1:0] pend_e_r, pend_e_nxt;
  logic             go_r, go_nxt;

  logic               ov_r, ov_nxt;
  logic [PRIME_W-1:0] op_r, op_nxt;
  logic [EXP_W-1:0]   oe_r, oe_nxt;
  logic               ol_r, ol_nxt;
  logic               on_r, on_nxt;

  logic [VB-1:0] v_in;
  logic          div_done;
  logic [VB-1:0] quo, rem;

  assign v_in = VB'(in_value);

  tdf_div #(.W(VB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go_r),
    .dividend  (rest_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    state_nxt  = state_r;
    rest_nxt   = rest_r;
    d_nxt      = d_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    pend_v_nxt = pend_v_r;
    pend_p_nxt = pend_p_r;
    pend_e_nxt = pend_e_r;
    go_nxt     = 1'b0;
    ov_nxt     = 1'b0;
    op_nxt     = op_r;
    oe_nxt     = oe_r;
    ol_nxt     = 1'b0;
    on_nxt     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (v_in < VB'(2)) begin
            // zero or one: single flagged result
            ov_nxt = 1'b1;
            op_nxt = '0;
            oe_nxt = '0;
            ol_nxt = 1'b1;
            on_nxt = 1'b1;
          end else begin
            rest_nxt   = v_in;
            d_nxt      = VB'(2);
            cnt_nxt    = '0;
            k_nxt      = '0;
            pend_v_nxt = 1'b0;
            go_nxt     = 1'b1;
            state_nxt  = S_WAIT;
          end
        end
      end

      S_WAIT: begin
        if (div_done) begin
          if (cnt_r != '0) begin
            // dividing out the current prime
            if (rem == '0) begin
              rest_nxt = quo;
              cnt_nxt  = cnt_r + 1'b1;
            end else begin
              // prime done: release held result, hold this one
              if (k_r < K_W'(MAX_RESULTS)) begin
                if (pend_v_r) begin
                  ov_nxt = 1'b1;
                  op_nxt = PRIME_W'(pend_p_r);
                  oe_nxt = pend_e_r;
                end
                pend_v_nxt = 1'b1;
                pend_p_nxt = d_r;
                pend_e_nxt = cnt_r;
                k_nxt      = k_r + 1'b1;
              end
              cnt_nxt = '0;
              d_nxt   = d_r + 1'b1;
            end
            go_nxt = 1'b1;
          end else if (d_r > quo) begin
            // d * d > rest: loop over
            if (rest_r != VB'(1) && k_r < K_W'(MAX_RESULTS)) begin
              if (pend_v_r) begin
                ov_nxt    = 1'b1;
                op_nxt    = PRIME_W'(pend_p_r);
                oe_nxt    = pend_e_r;
                state_nxt = S_TAIL;
              end else begin
                ov_nxt    = 1'b1;
                op_nxt    = PRIME_W'(rest_r);
                oe_nxt    = EXP_W'(1);
                ol_nxt    = 1'b1;
                state_nxt = S_IDLE;
              end
            end else begin
              ov_nxt    = 1'b1;
              op_nxt    = PRIME_W'(pend_p_r);
              oe_nxt    = pend_e_r;
              ol_nxt    = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            if (rem == '0) begin
              rest_nxt = quo;
              cnt_nxt  = EXP_W'(1);
            end else begin
              d_nxt = d_r + 1'b1;
            end
            go_nxt = 1'b1;
          end
        end
      end

      S_TAIL: begin
        ov_nxt    = 1'b1;
        op_nxt    = PRIME_W'(rest_r);
        oe_nxt    = EXP_W'(1);
        ol_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      ov_r    <= ov_nxt;
    end
    rest_r   <= rest_nxt;
    d_r      <= d_nxt;
    cnt_r    <= cnt_nxt;
    k_r      <= k_nxt;
    pend_v_r <= pend_v_nxt;
    pend_p_r <= pend_p_nxt;
    pend_e_r <= pend_e_nxt;
    op_r     <= op_nxt;
    oe_r     <= oe_nxt;
    ol_r     <= ol_nxt;
    on_r     <= on_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_prime_factor = op_r;
  assign out_exponent     = oe_r;
  assign out_last         = ol_r;
  assign out_no_factor    = on_r;

endmodule
